// ----- sv/bss_pkg.sv -----
package bss_pkg;

  localparam int unsigned MaxServersDef    = 16;
  localparam int unsigned HashTableSizeDef = 256;
  localparam logic [7:0]  OverloadLimit    = 8'd100;

  typedef enum logic [2:0] {
    ALG_RR     = 3'd0,
    ALG_LL     = 3'd1,
    ALG_LC     = 3'd2,
    ALG_STICKY = 3'd3,
    ALG_STATIC = 3'd4
  } alg_e;

  typedef enum logic [1:0] {
    CFG_ALG    = 2'd0,
    CFG_STRICT = 2'd1,
    CFG_WEIGHT = 2'd2,
    CFG_COUNT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_SCAN_SB,
    ST_CHECK,
    ST_RR,
    ST_MIN,
    ST_SLOT,
    ST_TBL_RD,
    ST_TBL_CHK,
    ST_STATIC,
    ST_TBL_WR,
    ST_OUT
  } state_e;

  // command from controller to datapath
  typedef struct packed {
    logic load_item;    // capture input item
    logic write_entry;  // write server entry
    logic scan_start;   // clear list, begin scan
    logic scan_step;    // test one server
    logic scan_sb;      // admit standby in this scan
    logic set_sb;       // mark standby admitted
    logic check_cur;    // validity check of remembered server
    logic rr_start;
    logic rr_step;
    logic min_start;
    logic min_step;
    logic min_ll;       // 1 load metric, 0 conn count
    logic slot_step;    // one step of slot reduction
    logic tbl_rd;
    logic tbl_chk;
    logic static_step;
    logic tbl_wr;
    logic set_result;   // register result of choose item
    logic set_none;
    logic set_zero;     // result of update item
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic req_choose;
    logic uri_present;
    logic scan_done;
    logic elig_empty;
    logic rr_done;
    logic min_done;
    logic slot_done;
    logic tbl_hit;
    logic static_done;
  } dp_sts_t;

endpackage

// ----- sv/bss_datapath.sv -----
module bss_datapath
  import bss_pkg::*;
#(
  parameter int unsigned MaxServers    = MaxServersDef,
  parameter int unsigned HashTableSize = HashTableSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic        strict_i,
  input  logic [7:0]  weight_i,
  input  logic [4:0]  count_i,
  input  logic [79:0] item_i,
  output logic [3:0]  chosen_o,
  output logic        no_server_o,
  output logic        used_sb_o,
  output logic        hit_o
);

  localparam int unsigned SW = (MaxServers > 1) ? $clog2(MaxServers) : 1;
  localparam int unsigned CW = $clog2(MaxServers + 1);
  localparam int unsigned HW = $clog2(HashTableSize);
  localparam int unsigned SlotMod = HashTableSize - 1;

  // captured item
  logic [79:0] item_q;
  logic        req_type;
  logic [3:0]  idx_in;
  logic [15:0] conns_in, max_in, load_in;
  logic        en_in, sb_in, uri_in;
  logic [7:0]  ext_in;
  assign req_type = item_q[0];
  assign idx_in   = item_q[4:1];
  assign conns_in = item_q[20:5];
  assign max_in   = item_q[36:21];
  assign en_in    = item_q[37];
  assign sb_in    = item_q[38];
  assign ext_in   = item_q[46:39];
  assign load_in  = item_q[62:47];
  assign uri_in   = item_q[63];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= item_i;
  end

  // server table
  logic [15:0] conn_q [MaxServers];
  logic [15:0] lim_q  [MaxServers];
  logic [1:0]  flg_q  [MaxServers];
  logic [7:0]  ext_q  [MaxServers];
  logic [15:0] ldv_q  [MaxServers];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxServers; i++) begin
        conn_q[i] <= '0;
        lim_q[i]  <= '0;
        flg_q[i]  <= '0;
        ext_q[i]  <= '0;
        ldv_q[i]  <= '0;
      end
    end else if (cmd_i.write_entry && (32'(idx_in) < MaxServers)) begin
      conn_q[SW'(idx_in)] <= conns_in;
      lim_q[SW'(idx_in)]  <= max_in;
      flg_q[SW'(idx_in)]  <= {sb_in, en_in};
      ext_q[SW'(idx_in)]  <= ext_in;
      ldv_q[SW'(idx_in)]  <= load_in;
    end
  end

  // validity: 0 valid, 1 standby, 2 invalid
  function automatic logic [1:0] chk(input logic [15:0] c, input logic [15:0] l,
                                     input logic [1:0] f, input logic [7:0] e,
                                     input logic strict);
    logic [1:0] r;
    if (!f[0] || c >= l) r = 2'd2;
    else if (strict && e > OverloadLimit) r = 2'd2;
    else r = f[1] ? 2'd1 : 2'd0;
    return r;
  endfunction

  // eligible list
  logic [SW-1:0] elig_q [MaxServers];
  logic [CW-1:0] n_q, scan_i_q;
  logic [CW-1:0] lim_cnt;
  logic          sb_q;
  logic [SW-1:0] cur_q;
  assign lim_cnt = (32'(count_i) > MaxServers) ? CW'(MaxServers) : CW'(count_i);

  logic [SW-1:0] sidx;
  logic [1:0]    sst;
  assign sidx = scan_i_q[SW-1:0];
  assign sst  = chk(conn_q[sidx], lim_q[sidx], flg_q[sidx], ext_q[sidx], strict_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && scan_i_q < lim_cnt &&
        (sst == 2'd0 || (sst == 2'd1 && cmd_i.scan_sb)))
      elig_q[n_q[SW-1:0]] <= sidx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= '0;
      scan_i_q <= '0;
      sb_q     <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        n_q      <= '0;
        scan_i_q <= '0;
      end else if (cmd_i.scan_step && scan_i_q < lim_cnt) begin
        scan_i_q <= scan_i_q + 1'b1;
        if (sst == 2'd0 || (sst == 2'd1 && cmd_i.scan_sb)) n_q <= n_q + 1'b1;
      end
      if (cmd_i.load_item)   sb_q <= 1'b0;
      else if (cmd_i.set_sb) sb_q <= 1'b1;
    end
  end

  // list walk counter, shared by round robin and min search
  logic [CW-1:0] k_q;
  logic          rr_found_q;
  logic [1:0]    cst;
  assign cst = chk(conn_q[cur_q], lim_q[cur_q], flg_q[cur_q], ext_q[cur_q], strict_i);

  logic [SW-1:0] ek;
  assign ek = elig_q[k_q[SW-1:0]];

  // least load metric of candidate and current pick
  logic [23:0] met_k, met_c;
  assign met_k = {8'd0, ldv_q[ek]} + conn_q[ek] * weight_i;
  assign met_c = {8'd0, ldv_q[cur_q]} + conn_q[cur_q] * weight_i;

  // slot reduction: hash mod (table size - 1), folding high bits onto low bits
  logic [15:0]   rem_q;
  logic [15:0]   srem_q;
  logic [HW-1:0] slot_q;
  logic          slot_done;
  assign slot_done = rem_q < 16'(SlotMod);

  // sticky table, valid bit plus server index
  logic [SW:0]   tbl_mem [HashTableSize];
  logic [SW:0]   tbl_rd_q;
  logic          tbl_rv_q;
  logic [HashTableSize-1:0] tbl_v_q;
  logic [SW-1:0] cand;
  logic [1:0]    tst;
  assign cand = tbl_rd_q[SW-1:0];
  assign tst  = chk(conn_q[cand], lim_q[cand], flg_q[cand], ext_q[cand], strict_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr) tbl_mem[slot_q] <= {1'b1, cur_q};
    if (cmd_i.tbl_rd) tbl_rd_q <= tbl_mem[slot_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_v_q  <= '0;
      tbl_rv_q <= 1'b0;
    end else begin
      if (cmd_i.tbl_wr) tbl_v_q[slot_q] <= 1'b1;
      if (cmd_i.tbl_rd) tbl_rv_q <= tbl_v_q[slot_q];
    end
  end

  // selection registers
  logic hit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= '0;
      k_q        <= '0;
      rr_found_q <= 1'b0;
      rem_q      <= '0;
      srem_q     <= '0;
      slot_q     <= '0;
      hit_q      <= 1'b0;
    end else begin
      if (cmd_i.load_item) begin
        rem_q <= item_i[79:64];
        hit_q <= 1'b0;
      end
      if (cmd_i.slot_step) begin
        if (rem_q == 16'(SlotMod)) rem_q <= '0;
        else if (!slot_done) rem_q <= (rem_q >> HW) + 16'(rem_q[HW-1:0]);
        else begin
          slot_q <= rem_q[HW-1:0];
          srem_q <= rem_q;
        end
      end
      if (cmd_i.check_cur && (cst == 2'd2 || (cst == 2'd1 && !sb_q)))
        cur_q <= elig_q[0];
      if (cmd_i.rr_start || cmd_i.min_start) begin
        k_q        <= '0;
        rr_found_q <= 1'b0;
      end else if (cmd_i.rr_step && k_q < n_q && !rr_found_q) begin
        if (ek == cur_q) begin
          rr_found_q <= 1'b1;
          cur_q <= (k_q + 1'b1 == n_q) ? elig_q[0] : elig_q[SW'(k_q + 1'b1)];
        end
        k_q <= k_q + 1'b1;
      end else if (cmd_i.min_step && k_q < n_q) begin
        if (cmd_i.min_ll ? (met_k < met_c) : (conn_q[ek] < conn_q[cur_q])) cur_q <= ek;
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.static_step) begin
        if (srem_q < 16'(n_q)) cur_q <= elig_q[srem_q[SW-1:0]];
        else srem_q <= srem_q - 16'(n_q);
      end
      if (cmd_i.tbl_chk && tbl_rv_q && (tst == 2'd0 || (tst == 2'd1 && sb_q))) begin
        cur_q <= cand;
        hit_q <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chosen_o    <= '0;
      no_server_o <= 1'b0;
      used_sb_o   <= 1'b0;
      hit_o       <= 1'b0;
    end else if (cmd_i.set_zero) begin
      chosen_o <= '0; no_server_o <= 1'b0; used_sb_o <= 1'b0; hit_o <= 1'b0;
    end else if (cmd_i.set_none) begin
      chosen_o <= '0; no_server_o <= 1'b1; used_sb_o <= 1'b0; hit_o <= 1'b0;
    end else if (cmd_i.set_result) begin
      chosen_o    <= 4'(cur_q);
      no_server_o <= 1'b0;
      used_sb_o   <= sb_q;
      hit_o       <= hit_q;
    end
  end

  assign sts_o.req_choose  = req_type;
  assign sts_o.uri_present = uri_in;
  assign sts_o.scan_done   = scan_i_q >= lim_cnt;
  assign sts_o.elig_empty  = n_q == '0;
  assign sts_o.rr_done     = rr_found_q || k_q >= n_q;
  assign sts_o.min_done    = k_q >= n_q;
  assign sts_o.slot_done   = slot_done;
  assign sts_o.tbl_hit     = tbl_rv_q && (tst == 2'd0 || (tst == 2'd1 && sb_q));
  assign sts_o.static_done = srem_q < 16'(n_q);

  // list never grows past the scanned count
  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= scan_i_q)
    else $error("eligible count above scan index");
  // a hit flag only follows a table check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hit_q) |-> $past(cmd_i.tbl_chk))
    else $error("hit set outside table check");
  // slot always below table size minus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tbl_rd |-> (32'(slot_q) < SlotMod))
    else $error("slot out of range");

endmodule

// ----- sv/bss_ctrl.sv -----
module bss_ctrl
  import bss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  logic [2:0] algorithm_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   ll_q, ll_d;      // min search uses load metric
  logic   wr_q, wr_d;      // min result goes to sticky table
  logic   ov_q;

  // output valid register, freed on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (state_q == ST_OUT) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end
  assign out_valid_o = ov_q;
  assign in_ready_o  = (state_q == ST_IDLE);

  logic hash_mode;
  assign hash_mode = sts_i.uri_present &&
                     (algorithm_i == ALG_STICKY || algorithm_i == ALG_STATIC);

  // next state
  always_comb begin
    state_d = state_q;
    ll_d    = ll_q;
    wr_d    = wr_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_UPDATE;
      ST_UPDATE: state_d = sts_i.req_choose ? ST_SCAN : ST_OUT;
      ST_SCAN: if (sts_i.scan_done) state_d = sts_i.elig_empty ? ST_SCAN_SB : ST_CHECK;
      ST_SCAN_SB: if (sts_i.scan_done && !sts_i.elig_empty) state_d = ST_CHECK;
                  else if (sts_i.scan_done) state_d = ST_OUT;
      ST_CHECK: begin
        ll_d = 1'b0;
        wr_d = 1'b0;
        unique case (algorithm_i)
          ALG_RR, ALG_LC: state_d = ST_RR;
          ALG_LL: begin state_d = ST_MIN; ll_d = 1'b1; end
          ALG_STICKY, ALG_STATIC: state_d = hash_mode ? ST_SLOT : ST_RR;
          default: state_d = ST_OUT;
        endcase
      end
      ST_RR: if (sts_i.rr_done)
               state_d = (algorithm_i == ALG_RR) ? ST_OUT : ST_MIN;
      ST_MIN: if (sts_i.min_done) state_d = wr_q ? ST_TBL_WR : ST_OUT;
      ST_SLOT: if (sts_i.slot_done)
                 state_d = (algorithm_i == ALG_STICKY) ? ST_TBL_RD : ST_STATIC;
      ST_TBL_RD: state_d = ST_TBL_CHK;
      ST_TBL_CHK: if (sts_i.tbl_hit) state_d = ST_OUT;
                  else begin state_d = ST_RR; wr_d = 1'b1; end
      ST_STATIC: if (sts_i.static_done) state_d = ST_OUT;
      ST_TBL_WR: state_d = ST_OUT;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    // hold in idle until output register drains
    if (state_q == ST_IDLE && ov_q && !out_ready_i) state_d = ST_IDLE;
  end

  logic busy_out;
  assign busy_out = ov_q && !out_ready_i;
  logic none_res;
  assign none_res = sts_i.scan_done && sts_i.elig_empty;

  // outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.min_ll = ll_q;
    unique case (state_q)
      ST_IDLE: cmd_o.load_item = in_valid_i;
      ST_UPDATE: begin
        cmd_o.write_entry = !sts_i.req_choose;
        cmd_o.scan_start  = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan_step  = 1'b1;
        cmd_o.scan_start = sts_i.scan_done && sts_i.elig_empty;
      end
      ST_SCAN_SB: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_sb   = 1'b1;
        cmd_o.set_sb    = sts_i.scan_done && !sts_i.elig_empty;
      end
      ST_CHECK: begin
        cmd_o.check_cur = 1'b1;
        cmd_o.rr_start  = 1'b1;
      end
      ST_RR: begin
        cmd_o.rr_step   = 1'b1;
        cmd_o.min_start = sts_i.rr_done;
      end
      ST_MIN: cmd_o.min_step = 1'b1;
      ST_SLOT: cmd_o.slot_step = 1'b1;
      ST_TBL_RD: cmd_o.tbl_rd = 1'b1;
      ST_TBL_CHK: begin
        cmd_o.tbl_chk  = 1'b1;
        cmd_o.rr_start = 1'b1;
      end
      ST_STATIC: cmd_o.static_step = 1'b1;
      ST_TBL_WR: cmd_o.tbl_wr = 1'b1;
      ST_OUT: begin
        if (!sts_i.req_choose) cmd_o.set_zero = 1'b1;
        else if (none_res)     cmd_o.set_none = 1'b1;
        else                   cmd_o.set_result = 1'b1;
      end
      default: ;
    endcase
    if (busy_out) cmd_o.load_item = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ll_q    <= 1'b0;
      wr_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ll_q    <= ll_d;
      wr_q    <= wr_d;
    end
  end

  // an item is only taken in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !busy_out) |=> state_q == ST_UPDATE)
    else $error("accepted item did not start");
  // result state always loads the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |=> out_valid_o)
    else $error("result lost");
  // table write only on sticky mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tbl_wr |-> algorithm_i == ALG_STICKY)
    else $error("table write outside sticky mode");

endmodule

// ----- sv/backend_server_selector.sv -----
// Backend server selector. Update items write one server entry; choose items
// return the chosen server under the configured mode. One item is in work at a
// time. A choose runs an eligibility scan (a second scan only when no
// non-standby server qualifies), then list walks (round robin and least load
// one walk, least connections and a sticky miss two). Hash modes fold the hash
// into a table slot; a sticky mode then reads the table, a static mode picks
// the list entry at slot modulo list length. The sticky table is a 256-entry
// memory with one valid flop per entry; its size must be a power of two.
// The result sits in an output register; the next item is taken once it drains.
module backend_server_selector
  import bss_pkg::*;
#(
  parameter int unsigned MaxServers    = MaxServersDef,
  parameter int unsigned HashTableSize = HashTableSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type, server_index, active_conns, max_conns, enabled, standby,
  // ext_load, load_metric, uri_present, uri_hash, zero pad
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // chosen_server, no_server, used_standby, hash_hit
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  logic [2:0] alg_q;
  logic       strict_q;
  logic [7:0] weight_q;
  logic [4:0] count_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q    <= ALG_RR;
      strict_q <= 1'b0;
      weight_q <= 8'd1;
      count_q  <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ALG:    alg_q    <= cfg_data_i[2:0];
        CFG_STRICT: strict_q <= cfg_data_i[0];
        CFG_WEIGHT: weight_q <= cfg_data_i;
        CFG_COUNT:  count_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    rdy;

  bss_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (rdy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .algorithm_i (alg_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  assign s_axis_tready = rdy && !(m_axis_tvalid && !m_axis_tready);

  bss_datapath #(.MaxServers(MaxServers), .HashTableSize(HashTableSize)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .strict_i    (strict_q),
    .weight_i    (weight_q),
    .count_i     (count_q),
    .item_i      (s_axis_tdata[79:0]),
    .chosen_o    (m_axis_tdata[3:0]),
    .no_server_o (m_axis_tdata[4]),
    .used_sb_o   (m_axis_tdata[5]),
    .hit_o       (m_axis_tdata[6])
  );
  assign m_axis_tdata[7] = 1'b0;

endmodule
